// ===== rtl/core/kdlp_pkg.sv =====
`default_nettype none

package kdlp_pkg;

    // Widths of the item fields and of the long-press time register.
    localparam int PIN_WIDTH  = 2;
    localparam int TICK_WIDTH = 16;

    localparam logic [TICK_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

    // Two-sample history codes: bit 0 is the newest pressed sample.
    localparam logic [1:0] HIST_PRESSED  = 2'b11;
    localparam logic [1:0] HIST_RELEASED = 2'b00;

    typedef logic [PIN_WIDTH-1:0]  pin_mask_t;
    typedef logic [TICK_WIDTH-1:0] tick_count_t;

    // What one key lane reports for the item being taken.
    typedef struct packed {
        logic short_press;
        logic long_press;
    } lane_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/kdlp_lane.sv =====
`default_nettype none

module kdlp_lane
    import kdlp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        pressed,
    input  wire tick_count_t long_press_ticks,
    output lane_flags_t      flags
);

    logic [1:0]  hist_reg;
    logic [1:0]  hist_next;
    logic        held_reg;
    logic        held_next;
    tick_count_t count_reg;
    tick_count_t count_next;

    always_comb
    begin
        hist_next   = {hist_reg[0], pressed};
        held_next   = held_reg;
        count_next  = count_reg;
        flags       = '0;
        if (hist_next == HIST_PRESSED)
        begin
            if (!held_reg)
            begin
                count_next = long_press_ticks;
                held_next  = 1'b1;
            end
            else if (count_reg != '0)
            begin
                count_next       = count_reg - tick_count_t'(1);
                flags.long_press = (count_reg == tick_count_t'(1));
            end
        end
        else if (hist_next == HIST_RELEASED && held_reg)
        begin
            // A release while time remains is a short press.
            flags.short_press = (count_reg != '0);
            held_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            held_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            hist_reg  <= hist_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    a_long_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        flags.long_press |-> held_reg && count_reg == tick_count_t'(1))
        else $error("long press flagged without a running hold");

    a_short_needs_time: assert property (@(posedge clk) disable iff (!rst_n)
        flags.short_press |-> held_reg && count_reg != '0)
        else $error("short press flagged without time remaining");

    a_press_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && hist_next == HIST_PRESSED) |=> held_reg)
        else $error("two pressed samples did not leave the key held");

endmodule

`default_nettype wire

// ===== rtl/core/kdlp_merge.sv =====
`default_nettype none

module kdlp_merge
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire lane_flags_t lane_flags [NUM_KEYS],
    output logic             load_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pin_mask_t        short_press_mask,
    output pin_mask_t        long_press_mask
);

    logic      valid_reg;
    pin_mask_t short_comb;
    pin_mask_t long_comb;
    pin_mask_t short_reg;
    pin_mask_t long_reg;

    // Only keys that have a pin in the field can report a press.
    for (genvar k = 0; k < PIN_WIDTH; k++)
    begin : g_bit
        if (k < NUM_KEYS)
        begin : g_lane
            assign short_comb[k] = lane_flags[k].short_press;
            assign long_comb[k]  = lane_flags[k].long_press;
        end
        else
        begin : g_none
            assign short_comb[k] = 1'b0;
            assign long_comb[k]  = 1'b0;
        end
    end

    assign load_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            short_reg <= short_comb;
            long_reg  <= long_comb;
        end
    end

    assign out_valid        = valid_reg;
    assign short_press_mask = short_reg;
    assign long_press_mask  = long_reg;

endmodule

`default_nettype wire

// ===== rtl/core/key_debounce_long_press_core.sv =====
`default_nettype none
// The result of an item is loaded into the output register at the edge that takes it.
// One item per cycle unless out_ready stalls; lanes and output register update in one edge.
// An item is taken while the output register is empty or its item is being taken.
// Reset (rst_n, asynchronous, active low) clears every key's history, held flag and
// countdown, empties the output register and sets the long-press time to 1000 ticks.

module key_debounce_long_press_core
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pin_mask_t   pin_levels,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pin_mask_t        short_press_mask,
    output pin_mask_t        long_press_mask,
    input  wire logic        cfg_we,
    input  wire tick_count_t cfg_wdata
);

    // The long-press time register. It is only sampled when a countdown loads,
    // so a write during a hold leaves the running countdown alone.
    tick_count_t long_press_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            long_press_ticks_reg <= cfg_wdata;
        end
    end

    logic        load_ready;
    logic        in_accept;
    lane_flags_t lane_flags [NUM_KEYS];

    assign in_ready  = load_ready;
    assign in_accept = in_valid && load_ready;

    // One lane per key. The pins are active low; keys beyond the field width
    // always read released, so they never hold and never report anything.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic pressed;

        if (k < PIN_WIDTH)
        begin : g_pin
            assign pressed = ~pin_levels[k];
        end
        else
        begin : g_idle
            assign pressed = 1'b0;
        end

        kdlp_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .step             (in_accept),
            .pressed          (pressed),
            .long_press_ticks (long_press_ticks_reg),
            .flags            (lane_flags[k])
        );
    end

    // The merge stage gathers the per-key flags into the two masks and holds
    // them in the output register until the item is taken.
    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (in_accept),
        .lane_flags       (lane_flags),
        .load_ready       (load_ready),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .short_press_mask (short_press_mask),
        .long_press_mask  (long_press_mask)
    );

endmodule

`default_nettype wire

// ===== dv/press_checker.sv =====
module press_checker
    import kdlp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire pin_mask_t   pin_levels,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire pin_mask_t   short_press_mask,
    input  wire pin_mask_t   long_press_mask,
    input  wire logic        cfg_we,
    input  wire tick_count_t cfg_wdata,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        pin_mask_t short_m;
        pin_mask_t long_m;
    } press_flags_t;

    // Our own copy of the per-key debounce state and of the long-press time.
    logic [1:0]  key_history   [PIN_WIDTH];
    logic        key_held      [PIN_WIDTH];
    tick_count_t key_countdown [PIN_WIDTH];
    tick_count_t press_ticks;

    press_flags_t expected_presses [$];
    int           mismatches = 0;
    int           in_flight = 0;

    assign fail_count    = mismatches;
    assign pending_count = in_flight;

    task automatic predict_presses(input pin_mask_t pins, output press_flags_t flags);
        logic [1:0] hist;
        flags = '0;
        for (int k = 0; k < PIN_WIDTH; k++) begin
            hist = {key_history[k][0], ~pins[k]};
            key_history[k] = hist;
            if (hist == HIST_PRESSED) begin
                if (!key_held[k]) begin
                    key_countdown[k] = press_ticks;
                    key_held[k] = 1'b1;
                end
                else if (key_countdown[k] != '0) begin
                    key_countdown[k] = key_countdown[k] - tick_count_t'(1);
                    if (key_countdown[k] == '0)
                        flags.long_m[k] = 1'b1;
                end
            end
            else if (hist == HIST_RELEASED && key_held[k]) begin
                if (key_countdown[k] != '0)
                    flags.short_m[k] = 1'b1;
                key_held[k] = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        press_flags_t seen;
        press_flags_t want;
        if (!rst_n) begin
            for (int k = 0; k < PIN_WIDTH; k++) begin
                key_history[k] = '0;
                key_held[k] = 1'b0;
                key_countdown[k] = '0;
            end
            press_ticks = LONG_PRESS_RESET;
            expected_presses.delete();
            in_flight = 0;
        end
        else begin
            // A result taken at this edge always belongs to an older item.
            if (out_valid && out_ready) begin
                seen.short_m = short_press_mask;
                seen.long_m  = long_press_mask;
                if (expected_presses.size() == 0) begin
                    $display("%0t: result with no item pending, got short %b long %b",
                             $time, seen.short_m, seen.long_m);
                    mismatches++;
                end
                else begin
                    want = expected_presses.pop_front();
                    if (seen.short_m !== want.short_m) begin
                        $display("%0t: short_press_mask expected %b, got %b",
                                 $time, want.short_m, seen.short_m);
                        mismatches++;
                    end
                    if (seen.long_m !== want.long_m) begin
                        $display("%0t: long_press_mask expected %b, got %b",
                                 $time, want.long_m, seen.long_m);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                predict_presses(pin_levels, want);
                expected_presses.push_back(want);
            end
            if (cfg_we)
                press_ticks = cfg_wdata;
            in_flight = expected_presses.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import kdlp_pkg::*;

    // Pin patterns for the directed part. The pins are active low, so a zero
    // bit means that key is pressed.
    localparam pin_mask_t BOTH_DOWN = 2'b00;
    localparam pin_mask_t ALL_UP    = 2'b11;
    localparam pin_mask_t KEY0_DOWN = 2'b10;
    localparam pin_mask_t KEY1_DOWN = 2'b01;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 200;

    // Ways the result side can throttle the block.
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} stall_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    pin_mask_t   pin_levels = ALL_UP;
    logic        out_valid;
    logic        out_ready = 1'b0;
    pin_mask_t   short_press_mask;
    pin_mask_t   long_press_mask;
    logic        cfg_we = 1'b0;
    tick_count_t cfg_wdata = '0;

    int fail_count;
    int pending_count;

    // Sender burst bookkeeping and the long-press time currently programmed.
    int burst_left = 0;
    int ticks_now = 1000;

    // Per-key state of the random press generator.
    logic key_down [PIN_WIDTH];
    int   run_left [PIN_WIDTH];

    key_debounce_long_press_core #(.NUM_KEYS(2)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pin_levels       (pin_levels),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .short_press_mask (short_press_mask),
        .long_press_mask  (long_press_mask),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    press_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pin_levels       (pin_levels),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .short_press_mask (short_press_mask),
        .long_press_mask  (long_press_mask),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offers one item and returns at the falling edge after it was taken.
    // At the start of each burst the sender may first drop valid for a random
    // gap; within a burst valid stays high from one item to the next.
    task automatic send_pins(input pin_mask_t pins);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        pin_levels <= pins;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering items and waits until every expected result was taken.
    // Every item yields a result, so an empty store means the block is idle.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    // Programs the long-press time; only called while the block is idle.
    task automatic write_ticks(input int ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= tick_count_t'(ticks);
        ticks_now = ticks;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Builds the next pin sample from per-key press and release runs. Press
    // runs last up to four past the long-press time, at most 44, so short and
    // long presses show up, with single-sample glitches now and then. A small
    // share of samples gets a random bit flipped as contact bounce.
    function automatic pin_mask_t next_pins();
        pin_mask_t pins;
        int cap;
        cap = ((ticks_now > 40) ? 40 : ticks_now) + 4;
        for (int k = 0; k < PIN_WIDTH; k++) begin
            if (run_left[k] == 0) begin
                key_down[k] = ~key_down[k];
                if (key_down[k])
                    run_left[k] = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(1, cap);
                else
                    run_left[k] = $urandom_range(1, 4);
            end
            pins[k] = ~key_down[k];
            run_left[k]--;
        end
        if ($urandom_range(0, 11) == 0)
            pins[$urandom_range(0, PIN_WIDTH - 1)] ^= 1'b1;
        return pins;
    endfunction

    initial
    begin : stimulus
        for (int k = 0; k < PIN_WIDTH; k++) begin
            key_down[k] = 1'b0;
            run_left[k] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Mixed samples at the reset value of the long-press time: a history of
        // one pressed and one released sample must change nothing visible.
        send_pins(KEY0_DOWN);
        send_pins(KEY1_DOWN);
        send_pins(ALL_UP);
        drain();

        // Shortest nonzero time: both keys flag a long press on the third
        // pressed sample, then the countdown sits at zero, so the release
        // flags no short press.
        write_ticks(1);
        repeat (4) send_pins(BOTH_DOWN);
        repeat (2) send_pins(ALL_UP);
        drain();

        // A zero long-press time never flags anything for the whole hold.
        write_ticks(0);
        repeat (3) send_pins(BOTH_DOWN);
        repeat (2) send_pins(ALL_UP);
        drain();

        // Largest time loads the countdown on key 0; rewriting the register
        // during the hold must not disturb the running countdown, so the
        // release still counts as a short press.
        write_ticks(65535);
        repeat (2) send_pins(KEY0_DOWN);
        drain();
        write_ticks(3);
        send_pins(KEY0_DOWN);
        repeat (2) send_pins(ALL_UP);
        drain();

        // Random part: several settings of the long-press time, each followed
        // by a run of press and release sequences. Keys may still be held when
        // the register changes, which is legal and covered by the predictor.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       write_ticks(1);
                1:       write_ticks($urandom_range(2, 6));
                2:       write_ticks(0);
                3:       write_ticks($urandom_range(7, 20));
                4:       write_ticks(65535);
                default: write_ticks($urandom_range(1, 40));
            endcase
            repeat (ITEMS_PER_PHASE) send_pins(next_pins());
            drain();
        end

        // Waiting on after the drain catches any stray result.
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // The result side stalls on its own pattern: stretches of constant
    // readiness, coin-flip readiness, and sparse readiness.
    initial
    begin : receiver
        stall_mode_e mode;
        int span;
        forever begin
            mode = stall_mode_e'($urandom_range(0, 2));
            span = $urandom_range(20, 80);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Far beyond the slowest correct run.
    initial
    begin : watchdog
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
